FILE: hdl/tamd_pkg.sv
// Shared types and constants for the terrain alpha map decoder.
// No dependencies; used by terrain_alpha_map_decoder.
`default_nettype none

package tamd_pkg;

   // Default map geometry
   localparam int MAP_SIDE_DEF   = 64;
   localparam int MAP_VALUES_DEF = 4096;

   // Latched decode mode
   localparam logic [1:0] MODE_SMALL   = 2'd0;
   localparam logic [1:0] MODE_BIG_RAW = 2'd1;
   localparam logic [1:0] MODE_BIG_RLE = 2'd2;

   // Run-length parser phase
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_FILL   = 2'd1;
   localparam logic [1:0] PH_COPY   = 2'd2;

   // Run header fields
   localparam logic [7:0] HDR_FILL_MASK  = 8'h80;
   localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_map;
      logic       compressed;
      logic       fix_edges;
   } req_type;

   typedef struct packed {
      logic [7:0] value_first;
      logic [7:0] value_second;
      logic       pair;
      logic       last_of_map;
   } rsp_type;

   // 4-bit alpha scaled to 8 bits: x * 17 == {x, x}
   function automatic logic [7:0] nib_to_alpha(input logic [3:0] nib);
      return {nib, nib};
   endfunction

endpackage

`default_nettype wire

FILE: hdl/tamd_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module tamd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write-first is not needed; read returns old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

`default_nettype wire

FILE: hdl/terrain_alpha_map_decoder.sv
// Terrain alpha map decoder top level: sequencer, shared counter adder, output register.
// Depends on tamd_pkg and tamd_ram.
`default_nettype none

// Decodes the raw bytes of one MAP_SIDE x MAP_SIDE alpha map into 8-bit alpha values,
// one or two per result transfer. Mode (big_alpha register, compressed flag) and edge
// fixing are latched by the byte that carries start_of_map. One byte is handled at a
// time by a small sequencer around a single shared out_count adder. A byte that yields
// one result goes from S_LOAD to S_EMIT; a small-alpha byte in the last row with edge
// fixing passes S_READ first for the row RAM read; a run header or a byte that gives
// nothing goes back to S_IDLE; a fill run passes S_FILL and S_EMIT once per result
// (two values each, but the last one may be single) for up to 64 results. A result
// waits in S_EMIT while rsp_ready is low. req_ready is high only while the sequencer
// is idle. The csr port is always ready and must only be written while the block is
// idle.
module terrain_alpha_map_decoder #(
   parameter int MAP_SIDE   = tamd_pkg::MAP_SIDE_DEF,
   parameter int MAP_VALUES = tamd_pkg::MAP_VALUES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tamd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tamd_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_data
);

   localparam int CW          = $clog2(MAP_VALUES + 2);
   localparam int XW          = $clog2(MAP_SIDE);
   localparam int HALF_SIDE   = MAP_SIDE / 2;
   localparam int SW          = $clog2(HALF_SIDE);
   localparam int LAST_ROW_AT = MAP_VALUES - MAP_SIDE;
   localparam int PREV_ROW_AT = MAP_VALUES - 2 * MAP_SIDE;
   localparam logic [CW-1:0] MAP_END = CW'(MAP_VALUES);

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_FILL = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]        state_ff,     state_in;
   logic              fill_ff,      fill_in;
   logic [7:0]        byte_ff,      byte_in;
   logic              big_alpha_ff, big_alpha_in;
   logic [1:0]        mode_ff,      mode_in;
   logic              fix_ff,       fix_in;
   logic [1:0]        phase_ff,     phase_in;
   logic [6:0]        run_left_ff,  run_left_in;
   logic [6:0]        rem_ff,       rem_in;
   logic [CW-1:0]     out_count_ff, out_count_in;
   logic [CW-1:0]     in_count_ff,  in_count_in;
   logic [XW-1:0]     col_ff,       col_in;
   tamd_pkg::rsp_type rsp_ff,       rsp_in;

   // Shared out_count adder
   logic [1:0]    step;
   logic [CW-1:0] count_sum;
   assign count_sum = out_count_ff + CW'(step);

   // Adder step: a pair of values or a single one
   always_comb begin
      case (state_ff)
         S_LOAD:  step = (mode_ff == tamd_pkg::MODE_SMALL) ? 2'd2 : 2'd1;
         S_READ:  step = 2'd2;
         S_FILL:  step = (rem_ff >= 7'd2) ? 2'd2 : 2'd1;
         default: step = 2'd1;
      endcase
   end

   // Column arithmetic for small mode
   logic [XW:0]   col_sum;
   logic [XW-1:0] col_next;
   logic [XW-2:0] half_col;
   logic [SW-1:0] slot;
   logic          edge_col;
   logic          last_row;
   logic          prev_row;

   assign col_sum  = {1'b0, col_ff} + (XW + 1)'(2);
   assign col_next = (col_sum >= (XW + 1)'(MAP_SIDE)) ?
                     XW'(col_sum - (XW + 1)'(MAP_SIDE)) : col_sum[XW-1:0];
   assign half_col = col_ff[XW-1:1];
   assign slot     = (half_col == (XW - 1)'(HALF_SIDE)) ? '0 : SW'(half_col);
   assign edge_col = fix_ff && (col_ff == XW'(MAP_SIDE - 2));
   assign last_row = int'(out_count_ff) >= LAST_ROW_AT;
   assign prev_row = !last_row && (int'(out_count_ff) >= PREV_ROW_AT);

   // Room left for a fill run, clamped to the run count
   logic [CW-1:0] room;
   logic [6:0]    fill_len;
   assign room     = MAP_END - out_count_ff;
   assign fill_len = (CW'(run_left_ff) < room) ? run_left_ff : room[6:0];

   // Row store for the second-to-last row
   logic       ram_we;
   logic [7:0] ram_rdata;

   tamd_ram #(
      .WIDTH (8),
      .DEPTH (HALF_SIDE)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (slot),
      .wr_data (byte_ff),
      .rd_data (ram_rdata)
   );

   // Small-mode values from the byte or from the stored row
   logic [7:0] small_src;
   logic [7:0] small_a;
   logic [7:0] small_b;
   assign small_src = (state_ff == S_READ) ? ram_rdata : byte_ff;
   assign small_a   = tamd_pkg::nib_to_alpha(small_src[3:0]);
   assign small_b   = edge_col ? small_a : tamd_pkg::nib_to_alpha(small_src[7:4]);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_EMIT);
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // Configuration register
   assign big_alpha_in = (csr_valid && csr_ready) ? csr_data : big_alpha_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      byte_in      = byte_ff;
      mode_in      = mode_ff;
      fix_in       = fix_ff;
      phase_in     = phase_ff;
      run_left_in  = run_left_ff;
      rem_in       = rem_ff;
      out_count_in = out_count_ff;
      in_count_in  = in_count_ff;
      col_in       = col_ff;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               byte_in  = req_data.data_byte;
               state_in = S_LOAD;
               if (req_data.start_of_map) begin
                  out_count_in = '0;
                  in_count_in  = '0;
                  phase_in     = tamd_pkg::PH_HEADER;
                  run_left_in  = '0;
                  col_in       = '0;
                  fix_in       = req_data.fix_edges;
                  if (!big_alpha_ff) begin
                     mode_in = tamd_pkg::MODE_SMALL;
                  end else if (req_data.compressed) begin
                     mode_in = tamd_pkg::MODE_BIG_RLE;
                  end else begin
                     mode_in = tamd_pkg::MODE_BIG_RAW;
                  end
               end
            end
         end

         S_LOAD: begin
            fill_in = 1'b0;
            if (out_count_ff >= MAP_END) begin
               state_in = S_IDLE;
            end else begin
               case (mode_ff)
                  tamd_pkg::MODE_SMALL: begin
                     ram_we = fix_ff && prev_row;
                     if (fix_ff && last_row) begin
                        state_in = S_READ;
                     end else begin
                        out_count_in        = count_sum;
                        col_in              = col_next;
                        rsp_in.value_first  = small_a;
                        rsp_in.value_second = small_b;
                        rsp_in.pair         = 1'b1;
                        rsp_in.last_of_map  = (count_sum == MAP_END);
                        state_in            = S_EMIT;
                     end
                  end
                  tamd_pkg::MODE_BIG_RAW: begin
                     out_count_in        = count_sum;
                     rsp_in.value_first  = byte_ff;
                     rsp_in.value_second = '0;
                     rsp_in.pair         = 1'b0;
                     rsp_in.last_of_map  = (count_sum == MAP_END);
                     state_in            = S_EMIT;
                  end
                  tamd_pkg::MODE_BIG_RLE: begin
                     if (in_count_ff >= MAP_END) begin
                        state_in = S_IDLE;
                     end else begin
                        in_count_in = in_count_ff + CW'(1);
                        case (phase_ff)
                           tamd_pkg::PH_HEADER: begin
                              run_left_in = 7'(byte_ff & tamd_pkg::HDR_COUNT_MASK);
                              if ((byte_ff & tamd_pkg::HDR_FILL_MASK) != '0) begin
                                 phase_in = tamd_pkg::PH_FILL;
                              end else if (run_left_in != '0) begin
                                 phase_in = tamd_pkg::PH_COPY;
                              end
                              state_in = S_IDLE;
                           end
                           tamd_pkg::PH_FILL: begin
                              rem_in      = fill_len;
                              run_left_in = '0;
                              phase_in    = tamd_pkg::PH_HEADER;
                              state_in    = S_FILL;
                           end
                           default: begin
                              // copy run: one value per byte
                              out_count_in        = count_sum;
                              rsp_in.value_first  = byte_ff;
                              rsp_in.value_second = '0;
                              rsp_in.pair         = 1'b0;
                              rsp_in.last_of_map  = (count_sum == MAP_END);
                              run_left_in         = run_left_ff - 7'd1;
                              if (run_left_in == '0) begin
                                 phase_in = tamd_pkg::PH_HEADER;
                              end
                              state_in = S_EMIT;
                           end
                        endcase
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_READ: begin
            // stored row byte is on the RAM output now
            out_count_in        = count_sum;
            col_in              = col_next;
            rsp_in.value_first  = small_a;
            rsp_in.value_second = small_b;
            rsp_in.pair         = 1'b1;
            rsp_in.last_of_map  = (count_sum == MAP_END);
            state_in            = S_EMIT;
         end

         S_FILL: begin
            if (rem_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               fill_in             = 1'b1;
               rem_in              = rem_ff - 7'(step);
               out_count_in        = count_sum;
               rsp_in.value_first  = byte_ff;
               rsp_in.value_second = (rem_ff >= 7'd2) ? byte_ff : 8'd0;
               rsp_in.pair         = (rem_ff >= 7'd2);
               rsp_in.last_of_map  = (count_sum == MAP_END);
               state_in            = S_EMIT;
            end
         end

         S_EMIT: begin
            if (rsp_ready) begin
               state_in = fill_ff ? S_FILL : S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= 1'b0;
         big_alpha_ff <= 1'b0;
         mode_ff      <= tamd_pkg::MODE_SMALL;
         fix_ff       <= 1'b0;
         phase_ff     <= tamd_pkg::PH_HEADER;
         run_left_ff  <= '0;
         rem_ff       <= '0;
         out_count_ff <= '0;
         in_count_ff  <= '0;
         col_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         big_alpha_ff <= big_alpha_in;
         mode_ff      <= mode_in;
         fix_ff       <= fix_in;
         phase_ff     <= phase_in;
         run_left_ff  <= run_left_in;
         rem_ff       <= rem_in;
         out_count_ff <= out_count_in;
         in_count_ff  <= in_count_in;
         col_ff       <= col_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire
